[rtl/core/bhq_pkg.sv]
// Package for the bitcrusher hold-and-quantize block.
// Holds register widths, reset values, register indexes and the config struct.
// No dependencies.
package bhq_pkg;

    localparam int HOLD_W     = 23;
    localparam int LEVELS_W   = 24;
    localparam int STEP_W     = 29;
    localparam int CFG_W      = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = HOLD_W + 1;
    localparam int LEVEL_FRAC = 8;
    localparam int STEP_FRAC  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_LEVELS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP    = 2'd2;

    localparam logic [HOLD_W-1:0]   HOLD_INTERVAL_RST = 23'd65536;
    localparam logic [LEVELS_W-1:0] QUANT_LEVELS_RST  = 24'd16776960;
    localparam logic [STEP_W-1:0]   QUANT_STEP_RST    = 29'd65537;

    localparam logic [CNT_W-1:0] ONE_SAMPLE = 24'd65536;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;
    localparam int MID_CNT_W = $clog2(MID_DEPTH) + 1;

    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    typedef struct packed {
        logic [HOLD_W-1:0]   hold_interval;
        logic [LEVELS_W-1:0] quant_levels;
        logic [STEP_W-1:0]   quant_step;
    } cfg_t;

endpackage

[rtl/core/bitcrusher_hold_and_quantize.sv]
// Top level of the bitcrusher: config registers, hold front end, middle queue,
// quantizer back end and result queue.
// Uses bhq_pkg, bhq_hold, bhq_quant, bhq_fifo.
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+---------------------------
//  input     | sample_in, channel             | push / full
//  result    | sample_out                     | pop / empty
//  config    | wr_index, wr_data              | wr_en, no wait
//
// One request per cycle while full is low; a request goes through the middle queue,
// the quantizer stages and the result queue. When the counter plus one sample
// reaches twice the interval or more (after an interval write, or with an interval
// below one sample) the remainder is found bit-serially; full stays high meanwhile.
// Reset clears config to defaults, all hold counters and held samples, and queues.
// full rises when the middle queue is full or the remainder unit is busy.
module bitcrusher_hold_and_quantize #(
    parameter int CHANNELS    = bhq_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = bhq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [SAMPLE_BITS-1:0]    sample_in,
    input  logic                             channel,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [SAMPLE_BITS-1:0]    sample_out,
    input  logic                             wr_en,
    input  logic [bhq_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [bhq_pkg::CFG_W-1:0]        wr_data
);

    import bhq_pkg::*;

    logic [HOLD_W-1:0]      hold_interval_reg;
    logic [LEVELS_W-1:0]    quant_levels_reg;
    logic [STEP_W-1:0]      quant_step_reg;
    cfg_t                   cfg;

    logic                   front_ready;
    logic                   mid_push;
    logic [SAMPLE_BITS-1:0] mid_push_data;
    logic                   mid_pop;
    logic [SAMPLE_BITS-1:0] mid_pop_data;
    logic                   mid_full;
    logic                   mid_empty;
    logic [MID_CNT_W-1:0]   mid_count;

    logic                   out_push;
    logic [SAMPLE_BITS-1:0] out_push_data;
    logic [SAMPLE_BITS-1:0] out_pop_data;
    logic                   out_full;
    logic [OUT_CNT_W-1:0]   out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_interval_reg <= HOLD_INTERVAL_RST;
            quant_levels_reg  <= QUANT_LEVELS_RST;
            quant_step_reg    <= QUANT_STEP_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HOLD_INTERVAL: hold_interval_reg <= wr_data[HOLD_W-1:0];
                REG_QUANT_LEVELS:  quant_levels_reg  <= wr_data[LEVELS_W-1:0];
                REG_QUANT_STEP:    quant_step_reg    <= wr_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.hold_interval = hold_interval_reg;
    assign cfg.quant_levels  = quant_levels_reg;
    assign cfg.quant_step    = quant_step_reg;

    assign full = !front_ready;

    bhq_hold #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .sample_in (sample_in),
        .channel   (channel),
        .ready     (front_ready),
        .q_full    (mid_full),
        .q_push    (mid_push),
        .q_data    (mid_push_data)
    );

    bhq_fifo #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_push_data),
        .pop       (mid_pop),
        .pop_data  (mid_pop_data),
        .full      (mid_full),
        .empty     (mid_empty),
        .count     (mid_count)
    );

    bhq_quant #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_empty  (mid_empty),
        .in_data   (mid_pop_data),
        .in_pop    (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_push_data)
    );

    bhq_fifo #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_push_data),
        .pop       (pop),
        .pop_data  (out_pop_data),
        .full      (out_full),
        .empty     (empty),
        .count     (out_count)
    );

    assign sample_out = out_pop_data;

    // result queue space is reserved before a sample enters the quantizer
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_push && out_full))
        else $error("result queue overflow");

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(mid_push && mid_full))
        else $error("middle queue overflow");

    a_mid_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(mid_pop && mid_empty))
        else $error("quantizer popped an empty queue");

    a_mid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |=> (mid_count != '0))
        else $error("middle queue lost a request");

endmodule

[rtl/core/bhq_fifo.sv]
// Small show-ahead register queue with occupancy count.
// Used between the hold front end and the quantizer, and for results.
// No package dependencies.
module bhq_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/bhq_hold.sv]
// Front end: per-channel hold counters and held samples (sample-rate reduction).
// Uses bhq_pkg; a bit-serial remainder handles counters far past the interval.
// Pushes the channel's held sample into the middle queue.
module bhq_hold #(
    parameter int CHANNELS    = bhq_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = bhq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bhq_pkg::cfg_t                 cfg,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          channel,
    output logic                          ready,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [SAMPLE_BITS-1:0]        q_data
);

    import bhq_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_W = $clog2(CNT_W);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MOD  = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [HOLD_W-1:0]      hold_count_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0] held_sample_reg [CHANNELS];

    logic [HOLD_W-1:0]      rem_reg;
    logic [HOLD_W-1:0]      rem_next;
    logic [CNT_W-1:0]       div_reg;
    logic [CNT_W-1:0]       div_next;
    logic [BIT_W-1:0]       bit_reg;
    logic [BIT_W-1:0]       bit_next;
    logic [SAMPLE_BITS-1:0] pend_sample_reg;
    logic [SAMPLE_BITS-1:0] pend_sample_next;
    logic [CH_W-1:0]        pend_ch_reg;
    logic [CH_W-1:0]        pend_ch_next;

    logic [CH_W-1:0]        ch_sel;
    logic                   accept;
    logic [CNT_W-1:0]       ivl;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W:0]         diff;
    logic                   reach;
    logic                   fast;
    logic [CNT_W-1:0]       rem_sh;
    logic [CNT_W-1:0]       rem_new;

    logic                   hc_we;
    logic                   held_we;
    logic [CH_W-1:0]        wr_idx;
    logic [HOLD_W-1:0]      hc_wdata;
    logic [SAMPLE_BITS-1:0] held_wdata;

    always_comb
    begin
        if (CHANNELS == 1)
        begin
            ch_sel = '0;
        end
        else
        begin
            ch_sel = CH_W'(channel);
        end
    end

    assign ready   = (state_reg == ST_IDLE) && !q_full;
    assign accept  = push && ready;
    assign ivl     = {1'b0, cfg.hold_interval};
    assign cnt     = {1'b0, hold_count_reg[ch_sel]} + ONE_SAMPLE;
    assign diff    = {1'b0, cnt} - {1'b0, ivl};
    assign reach   = !diff[CNT_W];
    assign fast    = (diff[CNT_W-1:0] < ivl);
    assign rem_sh  = {rem_reg, div_reg[CNT_W-1]};
    assign rem_new = (rem_sh >= ivl) ? rem_sh - ivl : rem_sh;

    always_comb
    begin
        state_next       = state_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        bit_next         = bit_reg;
        pend_sample_next = pend_sample_reg;
        pend_ch_next     = pend_ch_reg;
        hc_we            = 1'b0;
        held_we          = 1'b0;
        wr_idx           = ch_sel;
        hc_wdata         = '0;
        held_wdata       = sample_in;
        q_push           = 1'b0;
        q_data           = sample_in;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (ivl == '0)
                    begin
                        hc_we   = 1'b1;
                        held_we = 1'b1;
                        q_push  = 1'b1;
                    end
                    else if (reach)
                    begin
                        if (fast)
                        begin
                            hc_we    = 1'b1;
                            hc_wdata = diff[HOLD_W-1:0];
                            held_we  = 1'b1;
                            q_push   = 1'b1;
                        end
                        else
                        begin
                            state_next       = ST_MOD;
                            rem_next         = '0;
                            div_next         = cnt;
                            bit_next         = BIT_W'(CNT_W - 1);
                            pend_sample_next = sample_in;
                            pend_ch_next     = ch_sel;
                        end
                    end
                    else
                    begin
                        hc_we    = 1'b1;
                        hc_wdata = cnt[HOLD_W-1:0];
                        q_push   = 1'b1;
                        q_data   = held_sample_reg[ch_sel];
                    end
                end
            end
            ST_MOD:
            begin
                rem_next = rem_new[HOLD_W-1:0];
                div_next = div_reg << 1;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_IDLE;
                    wr_idx     = pend_ch_reg;
                    hc_we      = 1'b1;
                    hc_wdata   = rem_new[HOLD_W-1:0];
                    held_we    = 1'b1;
                    held_wdata = pend_sample_reg;
                    q_push     = 1'b1;
                    q_data     = pend_sample_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                hold_count_reg[i]  <= '0;
                held_sample_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            if (hc_we)
            begin
                hold_count_reg[wr_idx] <= hc_wdata;
            end
            if (held_we)
            begin
                held_sample_reg[wr_idx] <= held_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        pend_sample_reg <= pend_sample_next;
        pend_ch_reg     <= pend_ch_next;
    end

endmodule

[rtl/core/bhq_quant.sv]
// Back end: two-stage quantizer, round(|x| * levels) * step, rounded and saturated.
// Uses bhq_pkg; pulls from the middle queue only when the result queue has room
// for everything in flight.
module bhq_quant #(
    parameter int SAMPLE_BITS = bhq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bhq_pkg::cfg_t                   cfg,
    input  logic                            in_empty,
    input  logic [SAMPLE_BITS-1:0]          in_data,
    output logic                            in_pop,
    input  logic [bhq_pkg::OUT_CNT_W-1:0]   out_count,
    output logic                            out_push,
    output logic [SAMPLE_BITS-1:0]          out_data
);

    import bhq_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = SB + LEVELS_W;
    localparam int SH1 = SB - 1 + LEVEL_FRAC;
    localparam int NW  = PW + 1 - SH1;
    localparam int QW  = NW + STEP_W;
    localparam int SH2 = STEP_FRAC + 1 - SB;
    localparam int RW  = QW + 1 - SH2;

    logic              s1_valid_reg;
    logic              s1_neg_reg;
    logic [PW-1:0]     s1_prod_reg;
    logic              s2_valid_reg;
    logic              s2_neg_reg;
    logic [QW-1:0]     s2_q_reg;

    logic [OUT_CNT_W:0] used;
    logic               in_neg;
    logic [SB-1:0]      in_mag;
    logic [PW:0]        rnd1;
    logic [NW-1:0]      n_val;
    logic [QW:0]        rnd2;
    logic [RW-1:0]      r_val;
    logic               over_pos;
    logic               over_neg;

    assign used   = {1'b0, out_count} + (OUT_CNT_W+1)'(s1_valid_reg)
                  + (OUT_CNT_W+1)'(s2_valid_reg);
    assign in_pop = !in_empty && (used < (OUT_CNT_W+1)'(OUT_DEPTH));

    assign in_neg = in_data[SB-1];
    assign in_mag = in_neg ? (~in_data + 1'b1) : in_data;

    assign rnd1  = {1'b0, s1_prod_reg} + ((PW+1)'(1) << (SH1 - 1));
    assign n_val = rnd1[PW:SH1];

    assign rnd2     = {1'b0, s2_q_reg} + ((QW+1)'(1) << (SH2 - 1));
    assign r_val    = rnd2[QW:SH2];
    assign over_pos = |r_val[RW-1:SB-1];
    assign over_neg = (|r_val[RW-1:SB]) || (r_val[SB-1] && (|r_val[SB-2:0]));

    always_comb
    begin
        if (s2_neg_reg)
        begin
            out_data = over_neg ? {1'b1, {(SB-1){1'b0}}} : (~r_val[SB-1:0] + 1'b1);
        end
        else
        begin
            out_data = over_pos ? {1'b0, {(SB-1){1'b1}}} : r_val[SB-1:0];
        end
    end

    assign out_push = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg  <= in_neg;
        s1_prod_reg <= PW'(in_mag) * PW'(cfg.quant_levels);
        s2_neg_reg  <= s1_neg_reg;
        s2_q_reg    <= QW'(n_val) * QW'(cfg.quant_step);
    end

endmodule

[dv/bitcrusher_hold_and_quantize_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bitcrusher_hold_and_quantize: per-channel hold and quantizer.
// A directed part, then randomized config phases with bursty pushes and random pop stalls.
// Depends on bhq_pkg and the bitcrusher_hold_and_quantize RTL.
module bitcrusher_hold_and_quantize_tb;

    import bhq_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic signed [SW-1:0] S_MAX = 24'sh7fffff;
    localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 ch;
    } crush_req_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push = 1'b0;
    logic                   full;
    logic signed [SW-1:0]   sample_in = '0;
    logic                   channel = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic signed [SW-1:0]   sample_out;
    logic                   wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   wr_index = REG_HOLD_INTERVAL;
    logic [CFG_W-1:0]       wr_data = '0;

    crush_req_t             pending_reqs[$];
    logic signed [SW-1:0]   expected_out[$];
    logic signed [SW-1:0]   want_out;
    int unsigned            error_count = 0;
    logic                   start_hold_off = 1'b0;

    logic [HOLD_W-1:0]      cfg_hold;
    logic [LEVELS_W-1:0]    cfg_levels;
    logic [STEP_W-1:0]      cfg_step;
    logic [HOLD_W-1:0]      hold_cnt_m[CHANNELS_DEF];
    logic signed [SW-1:0]   held_m[CHANNELS_DEF];

    bitcrusher_hold_and_quantize dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample_in  (sample_in),
        .channel    (channel),
        .empty      (empty),
        .pop        (pop),
        .sample_out (sample_out),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // hold stage then quantizer; updates the channel state
    function automatic logic signed [SW-1:0] predict_crushed(input logic signed [SW-1:0] x,
                                                             input logic ch);
        logic [31:0] cnt;
        logic        neg;
        longint      xs;
        longint      res;
        logic [63:0] mag;
        logic [63:0] lvl_n;
        logic [63:0] r;
        cnt = {9'd0, hold_cnt_m[ch]} + 32'(ONE_SAMPLE);
        if (cfg_hold == '0)
        begin
            cnt = '0;
            held_m[ch] = x;
        end
        else if (cnt >= {9'd0, cfg_hold})
        begin
            cnt = cnt % {9'd0, cfg_hold};
            held_m[ch] = x;
        end
        hold_cnt_m[ch] = cnt[HOLD_W-1:0];

        xs = held_m[ch];
        neg = xs < 0;
        mag = neg ? 64'(-xs) : 64'(xs);
        lvl_n = (mag * 64'(cfg_levels) + (64'd1 << 30)) >> 31;
        r = (lvl_n * 64'(cfg_step) + 64'd256) >> 9;
        if (neg)
            res = (r > 64'd8388608) ? -longint'(8388608) : -longint'(r);
        else
            res = (r > 64'd8388607) ? longint'(8388607) : longint'(r);
        return res[SW-1:0];
    endfunction

    // driver: bursts of requests with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    crush_req_t  next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                expected_out.push_back(predict_crushed(sample_in, channel));
            if (!push || !full)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    push <= 1'b1;
                    sample_in <= next_req.sample;
                    channel <= next_req.ch;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left--;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: checks results, stalls on its own pattern
    int unsigned hold_off_left = 0;
    int unsigned window_left = 0;
    int unsigned pop_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_out.size() == 0)
                    flag_error($sformatf("result %0d with nothing expected", sample_out));
                else
                begin
                    want_out = expected_out.pop_front();
                    if (sample_out !== want_out)
                        flag_error($sformatf("sample_out expected %0d got %0d",
                                             want_out, sample_out));
                end
            end
            if (window_left == 0)
            begin
                window_left = $urandom_range(8, 64);
                pop_mode = $urandom_range(0, 3);
            end
            else
                window_left--;
            if (start_hold_off)
                hold_off_left = HOLD_OFF_CYCLES;
            if (hold_off_left != 0)
            begin
                hold_off_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (pop_mode)
                    0, 1: pop <= 1'b1;
                    2: pop <= $urandom_range(0, 1) != 0;
                    default: pop <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
                $display("[bitcrusher_hold_and_quantize] ERROR");
                $finish;
            end
        end
    end

    task automatic write_regs(input logic [HOLD_W-1:0] hold, input logic [LEVELS_W-1:0] lvls,
                              input logic [STEP_W-1:0] stp, input bit poke_unused);
        @(posedge clk);
        wr_en <= 1'b1;
        if (poke_unused)
        begin
            wr_index <= REG_UNUSED;
            wr_data <= CFG_W'($urandom);
            @(posedge clk);
        end
        wr_index <= REG_HOLD_INTERVAL;
        wr_data <= {6'($urandom), hold};
        @(posedge clk);
        wr_index <= REG_QUANT_LEVELS;
        wr_data <= {5'($urandom), lvls};
        @(posedge clk);
        wr_index <= REG_QUANT_STEP;
        wr_data <= stp;
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_hold = hold;
        cfg_levels = lvls;
        cfg_step = stp;
    endtask

    task automatic queue_sample(input logic signed [SW-1:0] s, input logic ch);
        crush_req_t req;
        req.sample = s;
        req.ch = ch;
        pending_reqs.push_back(req);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || push || expected_out.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        if ($urandom_range(0, 7) != 0)
            return SW'($urandom);
        case ($urandom_range(0, 4))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    task automatic pick_config(output logic [HOLD_W-1:0] hold, output logic [LEVELS_W-1:0] lvls,
                               output logic [STEP_W-1:0] stp);
        int unsigned bits;
        logic [63:0] lv;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                case ($urandom_range(0, 5))
                    0: hold = '0;
                    1: hold = 23'd1;
                    2: hold = 23'd65535;
                    3: hold = 23'd65536;
                    4: hold = 23'd6553600;
                    default: hold = '1;
                endcase
                case ($urandom_range(0, 3))
                    0: lvls = '0;
                    1: lvls = 24'd3840;
                    2: lvls = 24'd16776960;
                    default: lvls = '1;
                endcase
                case ($urandom_range(0, 3))
                    0: stp = '0;
                    1: stp = 29'd65537;
                    2: stp = 29'd286331154;
                    default: stp = '1;
                endcase
            end
            2, 3:
            begin
                hold = HOLD_W'($urandom);
                lvls = LEVELS_W'($urandom);
                stp = STEP_W'($urandom);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: hold = HOLD_W'($urandom_range(1, 8) << 16);
                    1: hold = HOLD_W'($urandom_range(65536, 655360));
                    default: hold = HOLD_W'($urandom_range(65536, 6553600));
                endcase
                bits = $urandom_range(4, 16);
                lv = (64'd1 << bits) - 1;
                lvls = LEVELS_W'(lv << 8);
                stp = STEP_W'(((64'd1 << 32) + lv / 2) / lv);
            end
        endcase
    endtask

    logic [HOLD_W-1:0]   ph_hold;
    logic [LEVELS_W-1:0] ph_levels;
    logic [STEP_W-1:0]   ph_step;

    initial
    begin
        cfg_hold = HOLD_INTERVAL_RST;
        cfg_levels = QUANT_LEVELS_RST;
        cfg_step = QUANT_STEP_RST;
        foreach (hold_cnt_m[i])
        begin
            hold_cnt_m[i] = '0;
            held_m[i] = '0;
        end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset, extremes on both channels
        @(negedge clk);
        for (int c = 0; c < 2; c++)
        begin
            queue_sample(S_MAX, c[0]);
            queue_sample(S_MIN, c[0]);
            queue_sample('0, c[0]);
            queue_sample(-1, c[0]);
            queue_sample(1, c[0]);
        end
        wait_drained();

        // zero hold interval, full-scale saturation
        write_regs('0, 24'd16776960, 29'd286331154, 1'b1);
        @(negedge clk);
        queue_sample(S_MAX, 1'b0);
        queue_sample(S_MIN, 1'b1);
        queue_sample(24'sd12345, 1'b0);
        wait_drained();

        // fractional interval, coarsest levels
        write_regs(23'd163840, 24'd3840, 29'd286331153, 1'b0);
        @(negedge clk);
        queue_sample(24'sd3000000, 1'b0);
        queue_sample(-24'sd3000000, 1'b0);
        queue_sample(24'sd700000, 1'b0);
        queue_sample(-24'sd1, 1'b1);
        wait_drained();

        // zero levels, long interval so counters build up
        write_regs(23'd6553600, '0, 29'd65537, 1'b0);
        @(negedge clk);
        queue_sample(S_MAX, 1'b1);
        queue_sample(S_MIN, 1'b1);
        queue_sample(24'sd4242, 1'b1);
        queue_sample(-24'sd4242, 1'b0);
        wait_drained();

        // interval below one sample with counters far above it, zero step
        write_regs(23'd1000, 24'd16776960, '0, 1'b0);
        @(negedge clk);
        queue_sample(24'sd1234567, 1'b1);
        queue_sample(-24'sd7654321, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 12; ph++)
        begin
            pick_config(ph_hold, ph_levels, ph_step);
            write_regs(ph_hold, ph_levels, ph_step, $urandom_range(0, 3) == 0);
            @(negedge clk);
            for (int k = 0; k < 125; k++)
                queue_sample(pick_sample(), 1'($urandom));
            if (ph == 2)
            begin
                @(posedge clk);
                start_hold_off <= 1'b1;
                @(posedge clk);
                start_hold_off <= 1'b0;
            end
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("[bitcrusher_hold_and_quantize] OK");
        else
            $display("[bitcrusher_hold_and_quantize] ERROR");
        $finish;
    end

endmodule
